// ===== sv/assert_macros.svh =====
// Assertion macros shared by the footprint transform RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is high
`define FPER_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication checked on the following cycle
`define FPER_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ===== sv/fper_pkg.sv =====
// Package for the footprint point expand/rotate core: widths, codes and the arctangent table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fper_pkg;

  // Coordinate format and pipeline depth
  localparam int COORD_WIDTH     = 32;
  localparam int CORDIC_STAGES   = 16;
  localparam int GUARD           = 4;
  localparam int MARGIN_WIDTH    = COORD_WIDTH - 1;
  localparam int HEADING_WIDTH   = 16;
  localparam int CFG_INDEX_WIDTH = 3;

  // Internal widths
  localparam int EXP_X_WIDTH   = COORD_WIDTH + 2;
  localparam int EXP_Y_WIDTH   = COORD_WIDTH + 1;
  localparam int ROT_WIDTH     = COORD_WIDTH + 10;
  localparam int ANG_WIDTH     = 32;
  localparam int GAIN_WIDTH    = 24;
  localparam int LO_WIDTH      = 16;
  localparam int HI_WIDTH      = ROT_WIDTH - LO_WIDTH;
  localparam int HI_PROD_WIDTH = HI_WIDTH + GAIN_WIDTH + 1;
  localparam int LO_PROD_WIDTH = LO_WIDTH + GAIN_WIDTH;
  localparam int SUM_WIDTH     = HI_PROD_WIDTH + LO_WIDTH + 1;
  localparam int SCALE_SHIFT   = GAIN_WIDTH + GUARD;
  localparam int COMP_WIDTH    = SUM_WIDTH - SCALE_SHIFT;
  localparam int WORLD_WIDTH   = COMP_WIDTH + 1;

  // 1/K of the CORDIC gain, Q0.24
  localparam logic [GAIN_WIDTH-1:0] INV_GAIN = 24'd10188014;
  localparam logic signed [COORD_WIDTH-1:0] ONE_Q16 = 32'sd65536;
  localparam logic [HEADING_WIDTH-1:0] EIGHTH_TURN = 16'd8192;

  // Register map
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_SIDE_MARGIN  = 3'd0,
    CFG_REAR_MARGIN  = 3'd1,
    CFG_FRONT_OFFSET = 3'd2,
    CFG_CENTER_X     = 3'd3,
    CFG_CENTER_Y     = 3'd4,
    CFG_HEADING      = 3'd5
  } cfg_index_t;

  // Coarse quarter-turn taken out before the CORDIC
  typedef enum logic [1:0] {
    QUAD_0   = 2'd0,
    QUAD_90  = 2'd1,
    QUAD_180 = 2'd2,
    QUAD_270 = 2'd3
  } quad_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic signed [ANG_WIDTH-1:0] atan_turn(input int unsigned idx);
    logic signed [ANG_WIDTH-1:0] a;
    case (idx)
      0:  a = 32'sd536870912;
      1:  a = 32'sd316933406;
      2:  a = 32'sd167458907;
      3:  a = 32'sd85004756;
      4:  a = 32'sd42667331;
      5:  a = 32'sd21354465;
      6:  a = 32'sd10679838;
      7:  a = 32'sd5340245;
      8:  a = 32'sd2670163;
      9:  a = 32'sd1335087;
      10: a = 32'sd667544;
      11: a = 32'sd333772;
      12: a = 32'sd166886;
      13: a = 32'sd83443;
      14: a = 32'sd41722;
      15: a = 32'sd20861;
      16: a = 32'sd10430;
      17: a = 32'sd5215;
      18: a = 32'sd2608;
      19: a = 32'sd1304;
      20: a = 32'sd652;
      21: a = 32'sd326;
      22: a = 32'sd163;
      23: a = 32'sd81;
      24: a = 32'sd41;
      25: a = 32'sd20;
      26: a = 32'sd10;
      27: a = 32'sd5;
      28: a = 32'sd3;
      29: a = 32'sd1;
      30: a = 32'sd1;
      default: a = 32'sd0;
    endcase
    return a;
  endfunction

endpackage

// ===== sv/footprint_point_expand_rotate_core.sv =====
// Pipeline from input acceptance to m_tvalid: expand, quadrant, 16 CORDIC stages,
//   two scaling stages, translate/saturate output register.
// Throughput: one point per cycle unless m_tready is low and no stage is empty; every stage
//   is registered and the gain multiply is split into two partial products of 51 and 40 bits.
// Reset: synchronous rst clears all stage valid bits and the configuration registers.
// No clearing pass; the block takes points from the first cycle after reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module footprint_point_expand_rotate_core import fper_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  // slave side: tdata = {point_y, point_x}, point_x in bits 31:0
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [2*COORD_WIDTH-1:0]     s_tdata,
  // master side: tdata = {world_y, world_x}, world_x in bits 31:0
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [2*COORD_WIDTH-1:0]     m_tdata,
  // tuser bit 0: saturated
  output logic                         m_tuser,
  // configuration write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [COORD_WIDTH-1:0]       cfg_data
);

  // stage map
  localparam int ST_EXP    = 0;
  localparam int ST_PRE    = 1;
  localparam int ST_CORDIC = 2;
  localparam int ST_MUL    = CORDIC_STAGES + 2;
  localparam int ST_SUM    = CORDIC_STAGES + 3;
  localparam int ST_OUT    = CORDIC_STAGES + 4;
  localparam int NST       = CORDIC_STAGES + 5;

  // configuration registers
  logic        [MARGIN_WIDTH-1:0]  side_margin;
  logic        [MARGIN_WIDTH-1:0]  rear_margin;
  logic signed [COORD_WIDTH-1:0]   front_offset;
  logic signed [COORD_WIDTH-1:0]   center_x;
  logic signed [COORD_WIDTH-1:0]   center_y;
  logic        [HEADING_WIDTH-1:0] heading;

  // pipeline control
  logic [NST-1:0] stage_valid;
  logic [NST-1:0] stage_ready;
  logic [NST-1:0] stage_in_valid;
  logic [NST-1:0] stage_load;

  // datapath
  logic signed [COORD_WIDTH-1:0]   point_x;
  logic signed [COORD_WIDTH-1:0]   point_y;
  logic signed [EXP_X_WIDTH-1:0]   exp_x_next;
  logic signed [EXP_Y_WIDTH-1:0]   exp_y_next;
  logic signed [EXP_X_WIDTH-1:0]   exp_x;
  logic signed [EXP_Y_WIDTH-1:0]   exp_y;
  logic        [HEADING_WIDTH-1:0] heading_adj;
  quad_t                           quad;
  logic        [HEADING_WIDTH-1:0] resid;
  logic signed [ROT_WIDTH-1:0]     wide_x;
  logic signed [ROT_WIDTH-1:0]     wide_y;
  logic signed [ROT_WIDTH-1:0]     quad_x;
  logic signed [ROT_WIDTH-1:0]     quad_y;
  logic signed [ROT_WIDTH-1:0]     pre_x;
  logic signed [ROT_WIDTH-1:0]     pre_y;
  logic signed [ANG_WIDTH-1:0]     pre_z;
  logic signed [ROT_WIDTH-1:0]     rot_x;
  logic signed [ROT_WIDTH-1:0]     rot_y;
  logic signed [COMP_WIDTH-1:0]    comp_x;
  logic signed [COMP_WIDTH-1:0]    comp_y;
  logic        [WORLD_WIDTH-1:0]   sum_x;
  logic        [WORLD_WIDTH-1:0]   sum_y;
  logic                            sat_x;
  logic                            sat_y;
  logic        [COORD_WIDTH-1:0]   world_x_next;
  logic        [COORD_WIDTH-1:0]   world_y_next;
  logic        [COORD_WIDTH-1:0]   world_x;
  logic        [COORD_WIDTH-1:0]   world_y;
  logic                            saturated;

  // ---------------------------------------------------------------------------
  // Configuration writes, always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_margin  <= '0;
      rear_margin  <= '0;
      front_offset <= '0;
      center_x     <= '0;
      center_y     <= '0;
      heading      <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SIDE_MARGIN:  side_margin  <= cfg_data[MARGIN_WIDTH-1:0];
        CFG_REAR_MARGIN:  rear_margin  <= cfg_data[MARGIN_WIDTH-1:0];
        CFG_FRONT_OFFSET: front_offset <= cfg_data;
        CFG_CENTER_X:     center_x     <= cfg_data;
        CFG_CENTER_Y:     center_y     <= cfg_data;
        CFG_HEADING:      heading      <= cfg_data[HEADING_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Valid/ready: a stage moves when the output is taken or it or any later stage is empty
  assign stage_in_valid = {stage_valid[NST-2:0], s_tvalid};

  for (genvar i = 0; i < NST; i++) begin : g_ready
    localparam logic [NST-1:0] LOW_MASK = (NST'(1) << i) - NST'(1);
    assign stage_ready[i] = m_tready | ~(&(stage_valid | LOW_MASK));
  end

  assign stage_load = stage_ready & stage_in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (stage_ready[i]) begin
          stage_valid[i] <= stage_in_valid[i];
        end
      end
    end
  end

  assign s_tready = stage_ready[ST_EXP];
  assign m_tvalid = stage_valid[ST_OUT];

  // ---------------------------------------------------------------------------
  // Stage: margin expansion of off-axis coordinates
  assign point_x = s_tdata[COORD_WIDTH-1:0];
  assign point_y = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];

  always_comb begin
    exp_x_next = EXP_X_WIDTH'(point_x);
    if (point_x > ONE_Q16 || point_x < -ONE_Q16) begin
      if (point_x[COORD_WIDTH-1]) begin
        exp_x_next = EXP_X_WIDTH'(point_x) - EXP_X_WIDTH'(rear_margin)
                   + EXP_X_WIDTH'(front_offset);
      end else begin
        exp_x_next = EXP_X_WIDTH'(point_x) + EXP_X_WIDTH'(front_offset);
      end
    end
    exp_y_next = EXP_Y_WIDTH'(point_y);
    if (point_y > ONE_Q16 || point_y < -ONE_Q16) begin
      if (point_y[COORD_WIDTH-1]) begin
        exp_y_next = EXP_Y_WIDTH'(point_y) - EXP_Y_WIDTH'(side_margin[MARGIN_WIDTH-1:1]);
      end else begin
        exp_y_next = EXP_Y_WIDTH'(point_y) + EXP_Y_WIDTH'(side_margin[MARGIN_WIDTH-1:1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_load[ST_EXP]) begin
      exp_x <= exp_x_next;
      exp_y <= exp_y_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage: exact quarter turn, residual angle in [-1/8, 1/8) turn
  assign heading_adj = heading + EIGHTH_TURN;
  assign quad        = quad_t'(heading_adj[HEADING_WIDTH-1:HEADING_WIDTH-2]);
  assign resid       = heading - {quad, {(HEADING_WIDTH-2){1'b0}}};
  assign wide_x      = ROT_WIDTH'(exp_x);
  assign wide_y      = ROT_WIDTH'(exp_y);

  always_comb begin
    case (quad)
      QUAD_90: begin
        quad_x = -wide_y;
        quad_y = wide_x;
      end
      QUAD_180: begin
        quad_x = -wide_x;
        quad_y = -wide_y;
      end
      QUAD_270: begin
        quad_x = wide_y;
        quad_y = -wide_x;
      end
      default: begin
        quad_x = wide_x;
        quad_y = wide_y;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (stage_load[ST_PRE]) begin
      pre_x <= quad_x <<< GUARD;
      pre_y <= quad_y <<< GUARD;
      pre_z <= {resid, 16'h0000};
    end
  end

  // ---------------------------------------------------------------------------
  // CORDIC micro-rotations
  fper_cordic u_cordic (
    .clk   (clk),
    .load  (stage_load[ST_CORDIC +: CORDIC_STAGES]),
    .x_in  (pre_x),
    .y_in  (pre_y),
    .z_in  (pre_z),
    .x_out (rot_x),
    .y_out (rot_y)
  );

  // ---------------------------------------------------------------------------
  // Gain compensation, one unit per coordinate
  fper_scale u_scale_x (
    .clk      (clk),
    .mul_load (stage_load[ST_MUL]),
    .sum_load (stage_load[ST_SUM]),
    .value    (rot_x),
    .scaled   (comp_x)
  );

  fper_scale u_scale_y (
    .clk      (clk),
    .mul_load (stage_load[ST_MUL]),
    .sum_load (stage_load[ST_SUM]),
    .value    (rot_y),
    .scaled   (comp_y)
  );

  // ---------------------------------------------------------------------------
  // Stage: translate to position and saturate
  assign sum_x = WORLD_WIDTH'(comp_x) + WORLD_WIDTH'(center_x);
  assign sum_y = WORLD_WIDTH'(comp_y) + WORLD_WIDTH'(center_y);

  // clamped when the bits above the coordinate's sign differ from it
  assign sat_x = !((&sum_x[WORLD_WIDTH-1:COORD_WIDTH-1]) || !(|sum_x[WORLD_WIDTH-1:COORD_WIDTH-1]));
  assign sat_y = !((&sum_y[WORLD_WIDTH-1:COORD_WIDTH-1]) || !(|sum_y[WORLD_WIDTH-1:COORD_WIDTH-1]));

  assign world_x_next = sat_x ? {sum_x[WORLD_WIDTH-1], {(COORD_WIDTH-1){!sum_x[WORLD_WIDTH-1]}}}
                              : sum_x[COORD_WIDTH-1:0];
  assign world_y_next = sat_y ? {sum_y[WORLD_WIDTH-1], {(COORD_WIDTH-1){!sum_y[WORLD_WIDTH-1]}}}
                              : sum_y[COORD_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (stage_load[ST_OUT]) begin
      world_x   <= world_x_next;
      world_y   <= world_y_next;
      saturated <= sat_x | sat_y;
    end
  end

  assign m_tdata = {world_y, world_x};
  assign m_tuser = saturated;

  // ---------------------------------------------------------------------------
  // Checks
  `FPER_ASSERT_NEXT(a_accept_enters, clk, rst, s_tvalid && s_tready, stage_valid[ST_EXP], "accepted request did not enter the first stage")
  `FPER_ASSERT_NEXT(a_first_holds, clk, rst, stage_valid[ST_EXP] && !stage_ready[ST_EXP], stage_valid[ST_EXP], "stalled request dropped from the first stage")
  `FPER_ASSERT_NEXT(a_count_kept, clk, rst, !(s_tvalid && s_tready) && !(m_tvalid && m_tready), $countones(stage_valid) == $past($countones(stage_valid)), "request count changed without a transfer")

endmodule

// ===== sv/fper_cordic.sv =====
// Pipelined CORDIC rotator: one micro-rotation per register stage.
// Depends on fper_pkg (widths, stage count, arctangent table).
`timescale 1ns / 1ps

module fper_cordic import fper_pkg::*; (
  input  logic                        clk,
  input  logic [CORDIC_STAGES-1:0]    load,
  input  logic signed [ROT_WIDTH-1:0] x_in,
  input  logic signed [ROT_WIDTH-1:0] y_in,
  input  logic signed [ANG_WIDTH-1:0] z_in,
  output logic signed [ROT_WIDTH-1:0] x_out,
  output logic signed [ROT_WIDTH-1:0] y_out
);

  logic signed [ROT_WIDTH-1:0] x_stage [CORDIC_STAGES];
  logic signed [ROT_WIDTH-1:0] y_stage [CORDIC_STAGES];
  // residual angle is not needed after the last stage
  logic signed [ANG_WIDTH-1:0] z_stage [CORDIC_STAGES-1];

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
    logic signed [ROT_WIDTH-1:0] xi;
    logic signed [ROT_WIDTH-1:0] yi;
    logic signed [ANG_WIDTH-1:0] zi;

    // stage input: port for the first stage, previous register otherwise
    if (g == 0) begin : g_first
      assign xi = x_in;
      assign yi = y_in;
      assign zi = z_in;
    end else begin : g_next
      assign xi = x_stage[g-1];
      assign yi = y_stage[g-1];
      assign zi = z_stage[g-1];
    end

    // rotate towards zero residual angle
    always_ff @(posedge clk) begin
      if (load[g]) begin
        if (!zi[ANG_WIDTH-1]) begin
          x_stage[g] <= xi - (yi >>> g);
          y_stage[g] <= yi + (xi >>> g);
        end else begin
          x_stage[g] <= xi + (yi >>> g);
          y_stage[g] <= yi - (xi >>> g);
        end
      end
    end

    if (g < CORDIC_STAGES - 1) begin : g_angle
      always_ff @(posedge clk) begin
        if (load[g]) begin
          if (!zi[ANG_WIDTH-1]) begin
            z_stage[g] <= zi - atan_turn(g);
          end else begin
            z_stage[g] <= zi + atan_turn(g);
          end
        end
      end
    end
  end

  assign x_out = x_stage[CORDIC_STAGES-1];
  assign y_out = y_stage[CORDIC_STAGES-1];

endmodule

// ===== sv/fper_scale.sv =====
// Gain compensation: multiply by 1/K, round half up and drop the guard and gain fraction.
// Depends on fper_pkg; two register stages (partial products, then sum).
`timescale 1ns / 1ps

module fper_scale import fper_pkg::*; (
  input  logic                         clk,
  input  logic                         mul_load,
  input  logic                         sum_load,
  input  logic signed [ROT_WIDTH-1:0]  value,
  output logic signed [COMP_WIDTH-1:0] scaled
);

  localparam logic [SUM_WIDTH-1:0] ROUND = SUM_WIDTH'(1) << (SCALE_SHIFT - 1);
  localparam int HI_EXT = SUM_WIDTH - HI_PROD_WIDTH - LO_WIDTH;

  logic signed [HI_WIDTH-1:0]      hi;
  logic        [LO_WIDTH-1:0]      lo;
  logic signed [HI_PROD_WIDTH-1:0] hi_prod;
  logic        [LO_PROD_WIDTH-1:0] lo_prod;
  logic        [SUM_WIDTH-1:0]     hi_term;
  logic        [SUM_WIDTH-1:0]     sum;

  // split the operand so each multiplier stays narrow
  assign hi = value[ROT_WIDTH-1:LO_WIDTH];
  assign lo = value[LO_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (mul_load) begin
      hi_prod <= hi * $signed({1'b0, INV_GAIN});
      lo_prod <= lo * INV_GAIN;
    end
  end

  // recombine, add half an LSB, keep the integer part
  assign hi_term = {{HI_EXT{hi_prod[HI_PROD_WIDTH-1]}}, hi_prod, {LO_WIDTH{1'b0}}};
  assign sum     = hi_term + SUM_WIDTH'(lo_prod) + ROUND;

  always_ff @(posedge clk) begin
    if (sum_load) begin
      scaled <= sum[SUM_WIDTH-1:SCALE_SHIFT];
    end
  end

endmodule

// ===== verif/fper_checker.sv =====
// Scoreboard for the footprint corner transform: watches the config, input and output channels.
// Predicts each world corner independently of the RTL; depends on fper_pkg for widths and codes.
`timescale 1ns / 1ps

module fper_checker import fper_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [2*COORD_WIDTH-1:0]   s_tdata,    // point_x, point_y
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [2*COORD_WIDTH-1:0]   m_tdata,    // world_x, world_y
  input  logic                       m_tuser,    // saturated
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]     cfg_data,
  output int                         mismatches,
  output int                         pending
);

  localparam int QUARTER_TURN = 16384;
  localparam int HALF_TURN    = 32768;
  localparam int FULL_TURN    = 65536;
  localparam longint COORD_MAX = (longint'(1) << (COORD_WIDTH - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] wx;
    logic [COORD_WIDTH-1:0] wy;
    logic                   sat;
  } corner_result_t;

  // local copy of the register file
  longint side_half    = 0;
  longint rear_len     = 0;
  longint front_shift  = 0;
  longint world_cx     = 0;
  longint world_cy     = 0;
  int     heading_ang  = 0;

  corner_result_t expected_corners[$];
  int errors = 0;

  // atan(2^-i) in 2^-32 turn units
  function automatic longint arctan_step(input int i);
    case (i)
      0: return 536870912;   1: return 316933406;   2: return 167458907;
      3: return 85004756;    4: return 42667331;    5: return 21354465;
      6: return 10679838;    7: return 5340245;     8: return 2670163;
      9: return 1335087;     10: return 667544;     11: return 333772;
      12: return 166886;     13: return 83443;      14: return 41722;
      15: return 20861;      16: return 10430;      17: return 5215;
      18: return 2608;       19: return 1304;       20: return 652;
      21: return 326;        22: return 163;        23: return 81;
      24: return 41;         25: return 20;         26: return 10;
      27: return 5;          28: return 3;          29: return 1;
      30: return 1;
      default: return 0;
    endcase
  endfunction

  // remove the CORDIC gain and the guard bits, round half up
  function automatic longint descale(input longint v);
    longint hi, lo, acc;
    hi  = v >>> 16;
    lo  = v - hi * 65536;
    acc = hi * longint'(INV_GAIN) + ((lo * longint'(INV_GAIN)) >>> 16);
    return (acc + (longint'(1) << (SCALE_SHIFT - 17))) >>> (SCALE_SHIFT - 16);
  endfunction

  function automatic longint clamp_world(input longint v, inout logic sat);
    if (v > COORD_MAX) begin
      sat = 1'b1;
      return COORD_MAX;
    end
    if (v < COORD_MIN) begin
      sat = 1'b1;
      return COORD_MIN;
    end
    return v;
  endfunction

  // expand, rotate by heading, translate and saturate one corner
  function automatic corner_result_t transform_corner(input logic signed [COORD_WIDTH-1:0] px,
                                                      input logic signed [COORD_WIDTH-1:0] py);
    longint x, y, t, z, dx, dy, r;
    int q, i;
    quad_t quad;
    logic sat;
    corner_result_t res;
    x = px;
    y = py;
    sat = 1'b0;
    // margins only apply off the unit band around each axis
    if (x > ONE_Q16 || x < -ONE_Q16)
      x = (x < 0) ? x - rear_len + front_shift : x + front_shift;
    if (y > ONE_Q16 || y < -ONE_Q16)
      y = (y < 0) ? y - side_half : y + side_half;
    // coarse quarter turn, exact
    q = ((heading_ang + int'(EIGHTH_TURN)) >> 14) & 3;
    quad = quad_t'(q[1:0]);
    r = heading_ang - q * QUARTER_TURN;
    if (r >= HALF_TURN)
      r = r - FULL_TURN;
    case (quad)
      QUAD_90: begin
        t = x; x = -y; y = t;
      end
      QUAD_180: begin
        x = -x; y = -y;
      end
      QUAD_270: begin
        t = x; x = y; y = -t;
      end
      default: ;
    endcase
    // fine rotation by micro-rotations
    x = x * (longint'(1) << GUARD);
    y = y * (longint'(1) << GUARD);
    z = r * 65536;
    for (i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - arctan_step(i);
      end else begin
        x = x + dx; y = y - dy; z = z + arctan_step(i);
      end
    end
    x = clamp_world(descale(x) + world_cx, sat);
    y = clamp_world(descale(y) + world_cy, sat);
    res.wx  = x[COORD_WIDTH-1:0];
    res.wy  = y[COORD_WIDTH-1:0];
    res.sat = sat;
    return res;
  endfunction

  always @(posedge clk) begin
    corner_result_t want;
    if (rst) begin
      side_half   = 0;
      rear_len    = 0;
      front_shift = 0;
      world_cx    = 0;
      world_cy    = 0;
      heading_ang = 0;
      expected_corners.delete();
    end else begin
      // register writes; unmapped indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SIDE_MARGIN:  side_half   = cfg_data[MARGIN_WIDTH-1:1];
          CFG_REAR_MARGIN:  rear_len    = cfg_data[MARGIN_WIDTH-1:0];
          CFG_FRONT_OFFSET: front_shift = $signed(cfg_data);
          CFG_CENTER_X:     world_cx    = $signed(cfg_data);
          CFG_CENTER_Y:     world_cy    = $signed(cfg_data);
          CFG_HEADING:      heading_ang = cfg_data[HEADING_WIDTH-1:0];
          default: ;
        endcase
      end
      // results against the oldest prediction
      if (m_tvalid && m_tready) begin
        if (expected_corners.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got %h user %b",
                   $time, m_tdata, m_tuser);
        end else begin
          want = expected_corners.pop_front();
          if (m_tdata[COORD_WIDTH-1:0] !== want.wx) begin
            errors++;
            $display("%0t: world_x expected %h got %h",
                     $time, want.wx, m_tdata[COORD_WIDTH-1:0]);
          end
          if (m_tdata[2*COORD_WIDTH-1:COORD_WIDTH] !== want.wy) begin
            errors++;
            $display("%0t: world_y expected %h got %h",
                     $time, want.wy, m_tdata[2*COORD_WIDTH-1:COORD_WIDTH]);
          end
          if (m_tuser !== want.sat) begin
            errors++;
            $display("%0t: saturated expected %b got %b", $time, want.sat, m_tuser);
          end
        end
      end
      // each request gives exactly one corner, queued behind the older ones
      if (s_tvalid && s_tready)
        expected_corners = {expected_corners,
                            transform_corner(s_tdata[COORD_WIDTH-1:0],
                                             s_tdata[2*COORD_WIDTH-1:COORD_WIDTH])};
    end
    pending    <= expected_corners.size();
    mismatches <= errors;
  end

endmodule

// ===== verif/tb.sv =====
// Top of the footprint corner transform testbench: clock, reset, stimulus and verdict.
// Depends on fper_pkg, footprint_point_expand_rotate_core and fper_checker.
`timescale 1ns / 1ps

module tb;
  import fper_pkg::*;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_B = 3'd7;
  localparam int QUIET_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 40;

  logic                       clk;
  logic                       rst       = 1'b1;
  logic                       s_tvalid  = 1'b0;
  logic                       s_tready;
  logic [2*COORD_WIDTH-1:0]   s_tdata   = '0;   // point_x, point_y
  logic                       m_tvalid;
  logic                       m_tready  = 1'b0;
  logic [2*COORD_WIDTH-1:0]   m_tdata;          // world_x, world_y
  logic                       m_tuser;          // saturated
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [COORD_WIDTH-1:0]     cfg_data  = '0;
  int mismatches;
  int pending;
  int quiet_cycles = 0;
  int stall_left = 0;
  int steady_left = 0;

  footprint_point_expand_rotate_core uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  fper_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)
      return $urandom_range(1, 3);
    if (r < 93)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // coordinates biased to the extremes and the unit band edges
  function automatic logic [COORD_WIDTH-1:0] rand_coord();
    int sel;
    logic [COORD_WIDTH-1:0] v;
    sel = $urandom_range(0, 9);
    case (sel)
      0: v = 32'h7fff_ffff;
      1: v = 32'h8000_0000;
      2: v = '0;
      3, 4: v = $urandom_range(65534, 65538);
      5: v = $urandom_range(0, 32'h00ff_ffff);
      default: v = $urandom();
    endcase
    if (sel >= 3 && sel <= 5 && $urandom_range(0, 1) == 1)
      v = -v;
    return v;
  endfunction

  function automatic logic [COORD_WIDTH-1:0] rand_margin();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 32'hffff_ffff;
      2, 3: return $urandom_range(0, 32'h000f_ffff);
      default: return $urandom();
    endcase
  endfunction

  // half the time a quarter-turn boundary; upper bits are junk
  function automatic logic [COORD_WIDTH-1:0] rand_heading();
    logic [HEADING_WIDTH-1:0] h;
    if ($urandom_range(0, 1) == 1) begin
      case ($urandom_range(0, 7))
        0: h = 16'd0;
        1: h = 16'd8191;
        2: h = 16'd8192;
        3: h = 16'd24575;
        4: h = 16'd24576;
        5: h = 16'd40960;
        6: h = 16'd57343;
        default: h = 16'd65535;
      endcase
    end else begin
      h = $urandom_range(0, 65535);
    end
    return {16'($urandom_range(0, 65535)), h};
  endfunction

  // directed corners as {y, x}: origin, unit band edges, axes, extremes
  function automatic logic [2*COORD_WIDTH-1:0] directed_corner(input int k);
    case (k)
      0:  return {32'h0000_0000, 32'h0000_0000};
      1:  return {32'h0001_0000, 32'h0001_0000};
      2:  return {32'hffff_0000, 32'hffff_0000};
      3:  return {32'hfffe_ffff, 32'h0001_0001};
      4:  return {32'h0001_0001, 32'hfffe_ffff};
      5:  return {32'h0000_0000, 32'h7fff_ffff};
      6:  return {32'h8000_0000, 32'h0000_0000};
      7:  return {32'h7fff_ffff, 32'h7fff_ffff};
      8:  return {32'h8000_0000, 32'h8000_0000};
      9:  return {32'h7fff_ffff, 32'h8000_0000};
      10: return {32'h8000_0000, 32'h7fff_ffff};
      default: return {32'hffff_ffff, 32'h0000_0001};
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [COORD_WIDTH-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // one request; valid stays up across back-to-back requests
  task automatic send_corner(input logic [2*COORD_WIDTH-1:0] xy, input bit no_gaps);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= xy;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    gap = (no_gaps || $urandom_range(0, 2) != 0) ? 0 : gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
  endtask

  // sink backpressure, with occasional stall-free stretches
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (steady_left > 0)
        steady_left = steady_left - 1;
      else if ($urandom_range(0, 199) == 0)
        steady_left = $urandom_range(50, 300);
      else if ($urandom_range(0, 2) == 0)
        stall_left = gap_len();
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int phase;
    int k;
    int n;
    bit burst;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed corners with registers at reset values
    for (k = 0; k < 12; k++)
      send_corner(directed_corner(k), 1'b0);
    s_tvalid <= 1'b0;
    wait_drained();

    // same corners with margins, offset and center at extremes and the heading at an eighth turn
    write_reg(CFG_SIDE_MARGIN, 32'hffff_ffff);
    write_reg(CFG_REAR_MARGIN, 32'hffff_ffff);
    write_reg(CFG_FRONT_OFFSET, 32'h7fff_ffff);
    write_reg(CFG_CENTER_X, 32'h7fff_ffff);
    write_reg(CFG_CENTER_Y, 32'h8000_0000);
    write_reg(CFG_HEADING, 32'h0000_2000);
    write_reg(CFG_SPARE_B, 32'hffff_ffff);
    for (k = 0; k < 12; k++)
      send_corner(directed_corner(k), 1'b0);
    s_tvalid <= 1'b0;
    wait_drained();

    // random phases, each under a fresh register setting
    for (phase = 0; phase < 8; phase++) begin
      write_reg(CFG_SIDE_MARGIN, rand_margin());
      write_reg(CFG_REAR_MARGIN, rand_margin());
      write_reg(CFG_FRONT_OFFSET, rand_coord());
      write_reg(CFG_CENTER_X, rand_coord());
      write_reg(CFG_CENTER_Y, rand_coord());
      write_reg(CFG_HEADING, rand_heading());
      write_reg(($urandom_range(0, 1) == 1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom());
      burst = ($urandom_range(0, 3) == 0);
      n = $urandom_range(60, 85);
      repeat (n) send_corner({rand_coord(), rand_coord()}, burst);
      s_tvalid <= 1'b0;
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
